// ----- design/pidl_pkg.sv -----
// Shared types and codes for the positional insert/delete list.
`default_nettype none

package pidl_pkg;

    // Field widths of one request and one result.
    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    // Action codes carried on the request side.
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    // Status codes carried on the result side.
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_CREATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UP   = 7'b0000010,
        S_PUT  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_DN   = 7'b0010000,
        S_DEC  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ----- design/positional_insert_delete_list.sv -----
// Top level of the positional insert/delete list with its sequencer and entry memory.
// Clear, error and unused actions go straight to the result; a read fetches its entry first;
// an insert or a delete also shifts the tail of the list. An append is an insert at
// the count. A new request is taken only after the last result reaches the output register,
// which waits for m_tready; shifts use the memory's single write port, one entry per cycle.
// Reset clears the count, the created flag, the sequencer and the result valid, not the memory.
`default_nettype none

module positional_insert_delete_list #(
    parameter int CAPACITY = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // position [7:0], value [39:8]
    input  wire logic [2:0]  s_tuser,   // action [2:0]
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // count [7:0], data [39:8]
    output logic [2:0]       m_tuser    // status [2:0]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;

    // Request fields.
    logic [pidl_pkg::ACTION_W-1:0] s_action;
    logic [pidl_pkg::POS_W-1:0]    s_position;
    logic [pidl_pkg::WORD_W-1:0]   s_value;

    assign s_action   = s_tuser;
    assign s_position = s_tdata[7:0];
    assign s_value    = s_tdata[39:8];

    // Control state.
    pidl_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          created_reg, created_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // Working and result registers.
    logic [CW-1:0]                 src_reg, src_next;
    logic [CW-1:0]                 dst_reg, dst_next;
    logic [CW-1:0]                 pos_reg, pos_next;
    logic [pidl_pkg::WORD_W-1:0]   value_reg, value_next;
    logic                          is_del_reg, is_del_next;
    logic [pidl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [pidl_pkg::WORD_W-1:0]   res_data_reg, res_data_next;
    logic [pidl_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [pidl_pkg::COUNT_W-1:0]  m_count_reg, m_count_next;
    logic [pidl_pkg::WORD_W-1:0]   m_data_reg, m_data_next;

    // Entry memory with registered read.
    logic [pidl_pkg::WORD_W-1:0] mem [CAPACITY];
    logic [pidl_pkg::WORD_W-1:0] rd_data_reg;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [pidl_pkg::WORD_W-1:0] wr_data;

    // Shared step unit: adds or subtracts one.
    logic [CW-1:0] unit_a;
    logic          unit_up;
    logic [CW-1:0] unit_y;

    // Request decode helpers.
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] ins_x;
    logic          list_full;

    assign s_tready = (state_reg == pidl_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_data_reg, m_count_reg};

    assign pos_x     = XW'(s_position);
    assign cnt_x     = XW'(count_reg);
    assign ins_x     = (s_action == pidl_pkg::ACT_APPEND) ? cnt_x : pos_x;
    assign list_full = (count_reg == CW'(CAPACITY));

    // Operand selection for the step unit follows the sequencer state.
    always_comb begin
        unit_a  = count_reg;
        unit_up = 1'b0;
        case (state_reg)
            pidl_pkg::S_UP: begin
                unit_a  = src_reg;
                unit_up = 1'b0;
            end
            pidl_pkg::S_RD, pidl_pkg::S_DN: begin
                unit_a  = src_reg;
                unit_up = 1'b1;
            end
            pidl_pkg::S_PUT: begin
                unit_a  = count_reg;
                unit_up = 1'b1;
            end
            default: begin
                unit_a  = count_reg;
                unit_up = 1'b0;
            end
        endcase
    end

    assign unit_y = unit_a + (unit_up ? CW'(1) : {CW{1'b1}});

    // Sequencer: decodes a request, then shifts entries one per cycle.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        created_next    = created_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        is_del_next     = is_del_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        m_data_next     = m_data_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        rd_en           = 1'b0;
        rd_addr         = unit_y[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = dst_reg[AW-1:0];
        wr_data         = rd_data_reg;

        case (state_reg)
            pidl_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    value_next      = s_value;
                    is_del_next     = (s_action == pidl_pkg::ACT_DELETE);
                    res_status_next = pidl_pkg::ST_OK;
                    res_data_next   = '0;
                    state_next      = pidl_pkg::S_DONE;
                    case (s_action)
                        pidl_pkg::ACT_CLEAR: begin
                            created_next = 1'b1;
                            count_next   = '0;
                        end
                        pidl_pkg::ACT_APPEND, pidl_pkg::ACT_INSERT: begin
                            if (!created_reg) begin
                                res_status_next = pidl_pkg::ST_NOT_CREATED;
                            end else if (list_full) begin
                                res_status_next = pidl_pkg::ST_FULL;
                            end else if (ins_x > cnt_x) begin
                                res_status_next = pidl_pkg::ST_BAD_POS;
                            end else begin
                                pos_next = ins_x[CW-1:0];
                                if (ins_x == cnt_x) begin
                                    state_next = pidl_pkg::S_PUT;
                                end else begin
                                    // Fetch the last entry; it moves up first.
                                    rd_en      = 1'b1;
                                    src_next   = unit_y;
                                    dst_next   = count_reg;
                                    state_next = pidl_pkg::S_UP;
                                end
                            end
                        end
                        pidl_pkg::ACT_DELETE, pidl_pkg::ACT_READ: begin
                            if (!created_reg) begin
                                res_status_next = pidl_pkg::ST_NOT_CREATED;
                            end else if (count_reg == '0) begin
                                res_status_next = pidl_pkg::ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                res_status_next = pidl_pkg::ST_BAD_POS;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_x[AW-1:0];
                                src_next   = pos_x[CW-1:0];
                                state_next = pidl_pkg::S_RD;
                            end
                        end
                        default: begin
                            res_status_next = pidl_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // Move one entry up per cycle, from the end down to the position.
            pidl_pkg::S_UP: begin
                wr_en = 1'b1;
                if (src_reg == pos_reg) begin
                    state_next = pidl_pkg::S_PUT;
                end else begin
                    rd_en    = 1'b1;
                    dst_next = src_reg;
                    src_next = unit_y;
                end
            end

            // Place the new word and grow the count.
            pidl_pkg::S_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = value_reg;
                count_next = unit_y;
                state_next = pidl_pkg::S_DONE;
            end

            // The addressed entry is back; a delete then closes the gap.
            pidl_pkg::S_RD: begin
                res_data_next = rd_data_reg;
                if (!is_del_reg) begin
                    state_next = pidl_pkg::S_DONE;
                end else if (unit_y == count_reg) begin
                    state_next = pidl_pkg::S_DEC;
                end else begin
                    rd_en      = 1'b1;
                    dst_next   = src_reg;
                    src_next   = unit_y;
                    state_next = pidl_pkg::S_DN;
                end
            end

            // Move one entry down per cycle until the last one has moved.
            pidl_pkg::S_DN: begin
                wr_en = 1'b1;
                if (unit_y == count_reg) begin
                    state_next = pidl_pkg::S_DEC;
                end else begin
                    rd_en    = 1'b1;
                    dst_next = src_reg;
                    src_next = unit_y;
                end
            end

            pidl_pkg::S_DEC: begin
                count_next = unit_y;
                state_next = pidl_pkg::S_DONE;
            end

            // Hand the result over once the output register is free.
            pidl_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_count_next  = 8'(count_reg);
                    m_data_next   = res_data_reg;
                    state_next    = pidl_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = pidl_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pidl_pkg::S_IDLE;
            count_reg    <= '0;
            created_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            created_reg  <= created_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        is_del_reg     <= is_del_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
        m_data_reg     <= m_data_next;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // The count never goes past the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Moving up, the destination sits right above the source.
    a_shift_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pidl_pkg::S_UP) |-> dst_reg == src_reg + CW'(1))
        else $error("upward shift source and destination out of step");

    // Moving down, the source sits right above the destination.
    a_shift_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pidl_pkg::S_DN) |-> src_reg == dst_reg + CW'(1))
        else $error("downward shift source and destination out of step");

    // The count only changes on a clear, an insert finish or a delete finish.
    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg))
        |-> ($past(state_reg) == pidl_pkg::S_IDLE || $past(state_reg) == pidl_pkg::S_PUT
             || $past(state_reg) == pidl_pkg::S_DEC))
        else $error("entry count changed outside its update states");

    // A new result appears only after the sequencer has finished a request.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == pidl_pkg::S_DONE)
        else $error("result raised without a finished request");

endmodule

`default_nettype wire
